// ===== rtl/core/slcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame parser package
// Shared constants and the result record type for the sync/length/checksum
// frame parser.
// ----------------------------------------------------------------------------
package slcfp_pkg;

  // Start-of-frame marker byte.
  localparam logic [7:0] SYNC_BYTE = 8'hAA;

  // Number of leading body bytes that are kept for the result fields.
  localparam int KEEP_DEPTH = 4;
  localparam int KEEP_IDX_W = $clog2(KEEP_DEPTH);

  // Body lengths that carry a value field, and the shortest that carries an id.
  localparam logic [7:0] LEN_VALUE_LO = 8'd4;
  localparam logic [7:0] LEN_VALUE_HI = 8'd5;
  localparam logic [7:0] LEN_WITH_ID  = 8'd2;

  // One decoded frame.
  typedef struct packed {
    logic [7:0]  frame_cmd;
    logic [7:0]  frame_id;
    logic [15:0] frame_value;
    logic [7:0]  frame_length;
    logic        checksum_ok;
  } frame_t;

endpackage

// ===== rtl/core/slcfp_parser.sv =====
// ----------------------------------------------------------------------------
// Frame parser phase machine
// Tracks hunt/length/body phases, counts body bytes, keeps the running sum
// and the first body bytes, and builds a frame record on the closing byte.
// ----------------------------------------------------------------------------
module slcfp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output slcfp_pkg::frame_t res
);
  import slcfp_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] keep_r   [KEEP_DEPTH];
  logic [7:0] keep_nxt [KEEP_DEPTH];
  logic [8:0] cnt_inc;
  logic       emit;

  assign cnt_inc = {1'b0, cnt_r} + 9'd1;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    keep_nxt  = keep_r;
    emit      = 1'b0;
    case (phase_r)
      PH_HUNT: begin
        if (accept && rx_byte == SYNC_BYTE) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        if (accept) begin
          if (rx_byte < SYNC_BYTE) begin
            len_nxt   = rx_byte;
            cnt_nxt   = 8'd0;
            sum_nxt   = 8'd0;
            phase_nxt = PH_BODY;
          end else if (rx_byte > SYNC_BYTE) begin
            phase_nxt = PH_HUNT;
          end
        end
      end
      PH_BODY: begin
        if (accept) begin
          if (cnt_r < 8'(KEEP_DEPTH)) begin
            keep_nxt[cnt_r[KEEP_IDX_W-1:0]] = rx_byte;
          end
          // An empty body closes on one byte that is not summed.
          if (len_r != 8'd0) begin
            sum_nxt = sum_r + rx_byte;
          end
          cnt_nxt = cnt_inc[7:0];
          if (cnt_inc >= {1'b0, len_r}) begin
            emit      = 1'b1;
            phase_nxt = PH_HUNT;
          end
        end
      end
      default: begin
        if (accept) begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
  end

  always_comb begin
    res.frame_cmd    = keep_nxt[0];
    res.frame_id     = (len_r >= LEN_WITH_ID) ? keep_nxt[1] : 8'd0;
    if (len_r == LEN_VALUE_LO) begin
      res.frame_value = {8'd0, keep_nxt[2]};
    end else if (len_r == LEN_VALUE_HI) begin
      res.frame_value = {keep_nxt[3], keep_nxt[2]};
    end else begin
      res.frame_value = 16'd0;
    end
    res.frame_length = len_r;
    res.checksum_ok  = (sum_nxt == 8'd0);
  end

  assign res_valid = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      sum_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
    keep_r <= keep_nxt;
  end

  // A closed frame always sends the parser back to hunting.
  a_emit_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> phase_r == PH_HUNT)
    else $error("parser did not return to hunting after a frame");

  // Inside a body the count never passes the length.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> (cnt_r < len_r) || (cnt_r == 8'd0))
    else $error("body count ran past body length");

  // A frame is only closed from the body phase on an accepted byte.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> accept && phase_r == PH_BODY)
    else $error("frame emitted outside the body phase");

endmodule

// ===== rtl/core/slcfp_out_buf.sv =====
// ----------------------------------------------------------------------------
// Frame output buffer
// Two-entry skid buffer that holds finished frames so the input side keeps
// running while the consumer stalls.
// ----------------------------------------------------------------------------
module slcfp_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  slcfp_pkg::frame_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output slcfp_pkg::frame_t out_data
);
  import slcfp_pkg::*;

  frame_t     head_r, tail_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;
  assign space     = (cnt_r != 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (pop && cnt_r == 2'd2) begin
      head_r <= tail_r;
    end
    if (push) begin
      if (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop)) begin
        head_r <= push_data;
      end else begin
        tail_r <= push_data;
      end
    end
  end

  // The buffer is never written while both entries are occupied.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("frame pushed into a full output buffer");

  // A frame pushed into an empty buffer shows up on the output next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    push && cnt_r == 2'd0 |=> out_valid && out_data == $past(push_data))
    else $error("pushed frame not presented at the output");

endmodule

// ===== rtl/core/sync_length_checksum_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Sync / length / checksum frame parser
// Byte-stream parser: finds the 0xAA start byte, takes a body length, sums
// the body and reports command, id, value, length and checksum status.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Direction  Content
//  --------  --------------------------------------  ---------  -------------
//  in        in_valid, in_ready, in_rx_byte          input      one rx byte
//  out       out_valid, out_ready, out_frame_*,      output     one frame
//            out_checksum_ok
//
// Every cycle one byte item can be accepted while in_ready is high; the phase
// machine, byte count and 8-bit running sum are updated by a single level of logic.
// A frame closed by a byte is written into the output buffer when that byte is
// accepted and reaches the out channel once the frames ahead of it are taken.
// A two-entry output buffer absorbs consumer stalls: in_ready drops only
// when both entries hold frames that have not been taken.
// Reset (synchronous, rst_n low) returns the parser to hunting for the
// start byte and empties the output buffer.
//
// Frame format: 0xAA, length L (below 0xAA), then L body bytes. A length
// byte of 0xAA is skipped; a length above 0xAA abandons the frame. The
// command is body byte 0, the id body byte 1 (zero for shorter bodies),
// the value body byte 2 for L = 4 or bytes 3:2 for L = 5, and zero
// otherwise. checksum_ok is set when the body bytes sum to zero mod 256.
// A zero-length body closes on the next byte, which is reported as the
// command with a good checksum. Frames with a bad sum are still reported,
// with checksum_ok low.
// ----------------------------------------------------------------------------
module sync_length_checksum_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_cmd,
  output logic [7:0]  out_frame_id,
  output logic [15:0] out_frame_value,
  output logic [7:0]  out_frame_length,
  output logic        out_checksum_ok
);
  import slcfp_pkg::*;

  logic   accept;
  logic   res_valid;
  logic   space;
  frame_t res;
  frame_t head;

  // A byte is taken whenever the buffer has room for a possible frame.
  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  slcfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  slcfp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign out_frame_cmd    = head.frame_cmd;
  assign out_frame_id     = head.frame_id;
  assign out_frame_value  = head.frame_value;
  assign out_frame_length = head.frame_length;
  assign out_checksum_ok  = head.checksum_ok;

endmodule

// ===== tb/slcfp_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame parser checker
// Watches both channels of the frame parser, predicts the decoded frame for
// every accepted byte and compares each delivered frame field by field.
// ----------------------------------------------------------------------------
module slcfp_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_frame_cmd,
  input  logic [7:0]  out_frame_id,
  input  logic [15:0] out_frame_value,
  input  logic [7:0]  out_frame_length,
  input  logic        out_checksum_ok,
  output int          mismatch_count,
  output int          frames_pending
);
  import slcfp_pkg::*;

  typedef enum logic [1:0] {
    HUNT_SYNC,
    TAKE_LENGTH,
    TAKE_BODY
  } parse_phase_t;

  parse_phase_t phase;
  logic [7:0]   body_len;
  logic [7:0]   body_cnt;
  logic [7:0]   body_sum;
  logic [7:0]   kept [KEEP_DEPTH];
  frame_t       frames_due [$];

  // Advances the predicted parser by one byte and queues a frame when the
  // byte closes one.
  task absorb_byte(input logic [7:0] b);
    frame_t f;
    case (phase)
      HUNT_SYNC: begin
        if (b == SYNC_BYTE) phase = TAKE_LENGTH;
      end
      TAKE_LENGTH: begin
        if (b < SYNC_BYTE) begin
          body_len = b;
          body_cnt = 8'd0;
          body_sum = 8'd0;
          phase    = TAKE_BODY;
        end else if (b > SYNC_BYTE) begin
          phase = HUNT_SYNC;
        end
      end
      default: begin
        if (body_cnt < KEEP_DEPTH) kept[body_cnt[KEEP_IDX_W-1:0]] = b;
        // An empty body still reports its closing byte, but never sums it.
        if (body_len != 8'd0) body_sum = body_sum + b;
        body_cnt = body_cnt + 8'd1;
        if (body_cnt >= body_len) begin
          phase          = HUNT_SYNC;
          f.frame_cmd    = kept[0];
          f.frame_id     = (body_len >= LEN_WITH_ID) ? kept[1] : 8'd0;
          if (body_len == LEN_VALUE_LO) begin
            f.frame_value = {8'd0, kept[2]};
          end else if (body_len == LEN_VALUE_HI) begin
            f.frame_value = {kept[3], kept[2]};
          end else begin
            f.frame_value = 16'd0;
          end
          f.frame_length = body_len;
          f.checksum_ok  = (body_sum == 8'd0);
          frames_due.push_back(f);
        end
      end
    endcase
  endtask

  task check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_t f;
    if (!rst_n) begin
      phase    = HUNT_SYNC;
      body_len = 8'd0;
      body_cnt = 8'd0;
      body_sum = 8'd0;
      for (int i = 0; i < KEEP_DEPTH; i++) kept[i] = 8'd0;
      frames_due.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && in_ready) absorb_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected frame, expected none, got cmd %h id %h value %h len %h ok %b",
                   $time, out_frame_cmd, out_frame_id, out_frame_value, out_frame_length,
                   out_checksum_ok);
          mismatch_count++;
        end else begin
          f = frames_due.pop_front();
          check_field("frame_cmd", {8'd0, f.frame_cmd}, {8'd0, out_frame_cmd});
          check_field("frame_id", {8'd0, f.frame_id}, {8'd0, out_frame_id});
          check_field("frame_value", f.frame_value, out_frame_value);
          check_field("frame_length", {8'd0, f.frame_length}, {8'd0, out_frame_length});
          check_field("checksum_ok", {15'd0, f.checksum_ok}, {15'd0, out_checksum_ok});
        end
      end
    end
    frames_pending = frames_due.size();
  end

endmodule

// ===== tb/sync_length_checksum_frame_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame parser testbench
// Feeds the sync/length/checksum frame parser a byte stream of directed and
// random frames under several back-pressure patterns; a checker module beside
// the block predicts and compares every frame, and this top gives the verdict.
// ----------------------------------------------------------------------------
module sync_length_checksum_frame_parser_tb;
  import slcfp_pkg::*;

  // Clock period is 20 ns; the run is cut off long after a correct run ends.
  localparam int  CLK_HALF      = 10;
  localparam int  DRAIN_CYCLES  = 20;
  localparam time RUN_LIMIT_NS  = 5_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_frame_cmd;
  logic [7:0]  out_frame_id;
  logic [15:0] out_frame_value;
  logic [7:0]  out_frame_length;
  logic        out_checksum_ok;

  int mismatch_count;
  int frames_pending;

  // Percentages of cycles in which the sender holds back an item and the
  // receiver refuses one; the stimulus phases set them as they go.
  int idle_pct  = 0;
  int stall_pct = 0;
  int bytes_sent = 0;

  sync_length_checksum_frame_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_cmd    (out_frame_cmd),
    .out_frame_id     (out_frame_id),
    .out_frame_value  (out_frame_value),
    .out_frame_length (out_frame_length),
    .out_checksum_ok  (out_checksum_ok)
  );

  slcfp_frame_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_cmd    (out_frame_cmd),
    .out_frame_id     (out_frame_id),
    .out_frame_value  (out_frame_value),
    .out_frame_length (out_frame_length),
    .out_checksum_ok  (out_checksum_ok),
    .mismatch_count   (mismatch_count),
    .frames_pending   (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // All inputs start at known values before the first clock edge.
  initial begin
    in_valid   = 1'b0;
    in_rx_byte = 8'd0;
    out_ready  = 1'b0;
  end

  // The receiver decides afresh at every falling edge whether it takes a
  // frame, so stalls land on every phase of the block's work.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Presents one byte item and returns at the falling edge after it was
  // accepted. Valid stays high with the same byte until the handshake, and
  // each call assigns in_valid at most once per time step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends a complete, well-formed frame of the given body length with random
  // body bytes. When fix_sum is set, the last body byte is chosen so that
  // the body sums to zero and the frame carries a good checksum.
  task automatic send_frame(input int unsigned len, input bit fix_sum);
    logic [7:0] b;
    logic [7:0] total;
    total = 8'd0;
    send_byte(SYNC_BYTE);
    send_byte(len[7:0]);
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (fix_sum && i == len - 1) b = 8'd0 - total;
      total = total + b;
      send_byte(b);
    end
    // An empty body still takes one closing byte.
    if (len == 0) send_byte(8'($urandom_range(255)));
  endtask

  // One random piece of traffic: mostly well-formed frames of short length,
  // a few long ones, and some noise, skipped length bytes, abandoned and
  // truncated frames so that the parser also has to resynchronize.
  task automatic send_random_traffic();
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    pick = $urandom_range(99);
    if (pick < 1) begin
      len = SYNC_BYTE - 1;
    end else if (pick < 4) begin
      len = $urandom_range(40, 8);
    end else begin
      len = $urandom_range(7, 0);
    end

    // Noise while hunting; any byte value may show up, the start byte too.
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
    end

    pick = $urandom_range(99);
    if (pick < 6) begin
      // A length byte above the start byte abandons the frame.
      send_byte(SYNC_BYTE);
      send_byte(8'($urandom_range(255, SYNC_BYTE + 1)));
    end else if (pick < 12) begin
      // The start byte repeated in the length slot is skipped.
      send_byte(SYNC_BYTE);
      send_frame(len, 1'($urandom_range(1)));
    end else if (pick < 17 && len > 1) begin
      // A truncated frame: the next frame's bytes land in this body.
      cut = $urandom_range(len - 1, 1);
      send_byte(SYNC_BYTE);
      send_byte(len[7:0]);
      repeat (cut) send_byte(8'($urandom_range(255)));
    end else begin
      send_frame(len, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [7:0] opening [28] = '{
      // The start byte in the length slot is skipped, a byte above it abandons.
      8'hAA, 8'hAA, 8'hFF,
      8'hAA, 8'hAB,
      // Empty body; the closing byte is itself the start byte value.
      8'hAA, 8'h00, 8'hAA,
      // Single zero byte: good checksum, no id.
      8'hAA, 8'h01, 8'h00,
      // Two bytes with a bad checksum, id present.
      8'hAA, 8'h02, 8'h12, 8'h34,
      // Four bytes summing to zero: value is the third byte.
      8'hAA, 8'h04, 8'h01, 8'h02, 8'h03, 8'hFA,
      // Five bytes summing to zero: value is bytes four and three.
      8'hAA, 8'h05, 8'hFF, 8'h00, 8'h34, 8'h12, 8'hBB
    };

    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase one: no idling on either side, directed frames first, then the
    // longest legal body and random traffic.
    idle_pct  = 0;
    stall_pct = 0;
    foreach (opening[i]) send_byte(opening[i]);
    send_frame(SYNC_BYTE - 1, 1'b1);
    send_frame(7, 1'b0);
    while (bytes_sent < 350) send_random_traffic();

    // Phase two: the sender is mostly idle.
    idle_pct = 85;
    while (bytes_sent < 700) send_random_traffic();

    // Phase three: the receiver mostly stalls, so the output buffer fills
    // and in_ready drops.
    idle_pct  = 0;
    stall_pct = 85;
    while (bytes_sent < 1050) send_random_traffic();

    // Phase four: both sides hold back a third of the time.
    idle_pct  = 33;
    stall_pct = 33;
    while (bytes_sent < 1400) send_random_traffic();
    in_valid <= 1'b0;

    // Let every predicted frame come out, then watch a little longer for
    // frames that should never appear.
    while (frames_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: a stuck handshake or a frame that never arrives ends here.
  initial begin
    #RUN_LIMIT_NS;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sync_length_checksum_frame_parser.f =====
rtl/core/slcfp_pkg.sv
rtl/core/slcfp_parser.sv
rtl/core/slcfp_out_buf.sv
rtl/core/sync_length_checksum_frame_parser.sv
tb/slcfp_frame_checker.sv
tb/sync_length_checksum_frame_parser_tb.sv
